// ----- rtl/core/alm_pkg.sv -----
package alm_pkg;

    // Fixed widths of the result fields
    localparam int LEVEL_W = 16;
    localparam int COUNT_W = 32;
    localparam int LEN_W   = 13;

    // Defaults for the top-level parameters
    localparam int BLOCK_MAX_DEFAULT   = 4096;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // Noise floor after reset: 1.0 in Q1.15
    localparam int FLOOR_ONE = 32768;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic take;       // input transfer this cycle
        logic load;       // block closes: snapshot sums, update hold and counters
        logic div_step;   // one restoring-division step
        logic sqrt_init;  // load the root unit from the quotient
        logic sqrt_step;  // one digit of the square root
        logic publish;    // move the finished result into the output register
    } alm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic close;      // the offered sample closes a block
        logic out_busy;   // output register holds a result not taken this cycle
    } alm_stat_t;

endpackage

// ----- rtl/core/alm_ctrl.sv -----
module alm_ctrl
    import alm_pkg::*;
#(
    parameter int BLOCK_MAX   = BLOCK_MAX_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  alm_stat_t stat,
    output alm_cmd_t  cmd
);

    localparam int CNT_W      = $clog2(BLOCK_MAX + 1);
    localparam int DIV_STEPS  = 2 * SAMPLE_BITS - 2 + CNT_W;
    localparam int ROOT_STEPS = SAMPLE_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS + 1);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIV       = 3'd1;
    localparam logic [2:0] S_ROOT_INIT = 3'd2;
    localparam logic [2:0] S_ROOT      = 3'd3;
    localparam logic [2:0] S_DONE      = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        in_ready   = (state_reg == S_IDLE);
        cmd.take   = in_valid & in_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.take && stat.close)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_ROOT_INIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_ROOT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                // hold the result until the output register frees up
                if (!stat.out_busy)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ----- rtl/core/alm_dp.sv -----
module alm_dp
    import alm_pkg::*;
#(
    parameter int BLOCK_MAX   = BLOCK_MAX_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  alm_cmd_t                      cmd,
    output alm_stat_t                     stat,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    input  logic                          overflow,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [LEVEL_W-1:0]            rms_level,
    output logic [LEVEL_W-1:0]            mean_abs,
    output logic [LEVEL_W-1:0]            peak_level,
    output logic [LEVEL_W-1:0]            floor_level,
    output logic [COUNT_W-1:0]            blocks_seen,
    output logic [COUNT_W-1:0]            blocks_dropped,
    output logic [LEN_W-1:0]              block_length
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CNT_W = $clog2(BLOCK_MAX + 1);
    localparam int SQ_W  = 2 * SB - 2 + CNT_W;
    localparam int ABS_W = SB - 1 + CNT_W;
    localparam int QW    = 2 * SB - 1;
    localparam int FL_W  = (SB > 16) ? SB : 16;

    // block accumulators
    logic [SQ_W-1:0]  sq_sum_reg;
    logic [ABS_W-1:0] abs_sum_reg;
    logic [SB-1:0]    block_peak_reg;
    logic [CNT_W-1:0] tally_reg;

    // running state across blocks
    logic [SB-1:0]      peak_hold_reg;
    logic [FL_W-1:0]    floor_reg;
    logic [COUNT_W-1:0] seen_reg;
    logic [COUNT_W-1:0] dropped_reg;

    // closed block, waiting for the divider and root unit
    logic [SB-1:0]      res_peak_reg;
    logic [COUNT_W-1:0] res_seen_reg;
    logic [COUNT_W-1:0] res_dropped_reg;
    logic [CNT_W-1:0]   res_len_reg;

    // divider: dividends shift out as quotients shift in
    logic [CNT_W-1:0] div_n_reg;
    logic [SQ_W-1:0]  dq_sq_reg;
    logic [SQ_W-1:0]  dq_abs_reg;
    logic [CNT_W-1:0] rem_sq_reg;
    logic [CNT_W-1:0] rem_abs_reg;

    // root unit
    logic [QW-1:0] root_v_reg;
    logic [QW:0]   root_reg;
    logic [QW-1:0] root_bit_reg;

    // output register
    logic               out_valid_reg;
    logic [LEVEL_W-1:0] rms_out_reg;
    logic [LEVEL_W-1:0] mean_out_reg;
    logic [LEVEL_W-1:0] peak_out_reg;
    logic [LEVEL_W-1:0] floor_out_reg;
    logic [COUNT_W-1:0] seen_out_reg;
    logic [COUNT_W-1:0] dropped_out_reg;
    logic [LEN_W-1:0]   len_out_reg;

    logic [SB-1:0]    mag;
    logic [2*SB-1:0]  mag_sq;
    logic [SQ_W-1:0]  sq_with;
    logic [ABS_W-1:0] abs_with;
    logic [SB-1:0]    peak_with;
    logic [CNT_W-1:0] tally_with;
    logic             full;

    logic [SQ_W-1:0]  snap_sq;
    logic [ABS_W-1:0] snap_abs;
    logic [SB-1:0]    snap_peak;
    logic [CNT_W-1:0] snap_n;
    logic             snap_ovf;

    logic [CNT_W:0]   trial_sq, trial_abs;
    logic             ge_sq, ge_abs;

    logic [QW:0]      root_trial;
    logic             root_ge;

    logic [FL_W-1:0]  floor_pub;

    // sample magnitude; the most negative code maps to 2^(SB-1)
    assign mag       = sample[SB-1] ? (~sample + 1'b1) : sample;
    assign mag_sq    = mag * mag;
    assign sq_with   = sq_sum_reg + SQ_W'(mag_sq);
    assign abs_with  = abs_sum_reg + ABS_W'(mag);
    assign peak_with = (mag > block_peak_reg) ? mag : block_peak_reg;
    assign tally_with = tally_reg + 1'b1;
    assign full      = (tally_reg == CNT_W'(BLOCK_MAX));

    assign stat.close    = full | last;
    assign stat.out_busy = out_valid_reg & ~out_ready;

    // a full block closes without the arriving sample and without overflow
    assign snap_sq   = full ? sq_sum_reg     : sq_with;
    assign snap_abs  = full ? abs_sum_reg    : abs_with;
    assign snap_peak = full ? block_peak_reg : peak_with;
    assign snap_n    = full ? tally_reg      : tally_with;
    assign snap_ovf  = ~full & overflow;

    assign trial_sq  = {rem_sq_reg, dq_sq_reg[SQ_W-1]};
    assign trial_abs = {rem_abs_reg, dq_abs_reg[SQ_W-1]};
    assign ge_sq     = (trial_sq >= {1'b0, div_n_reg});
    assign ge_abs    = (trial_abs >= {1'b0, div_n_reg});

    assign root_trial = root_reg + {1'b0, root_bit_reg};
    assign root_ge    = ({1'b0, root_v_reg} >= root_trial);

    assign floor_pub = ((root_reg != '0) && (root_reg < (QW + 1)'(floor_reg)))
                       ? FL_W'(root_reg) : floor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_sum_reg     <= '0;
            abs_sum_reg    <= '0;
            block_peak_reg <= '0;
            tally_reg      <= '0;
            peak_hold_reg  <= '0;
            floor_reg      <= FL_W'(FLOOR_ONE);
            seen_reg       <= '0;
            dropped_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                priority if (full)
                begin
                    // arriving sample opens the next block
                    sq_sum_reg     <= SQ_W'(mag_sq);
                    abs_sum_reg    <= ABS_W'(mag);
                    block_peak_reg <= mag;
                    tally_reg      <= CNT_W'(1);
                end
                else if (last)
                begin
                    sq_sum_reg     <= '0;
                    abs_sum_reg    <= '0;
                    block_peak_reg <= '0;
                    tally_reg      <= '0;
                end
                else
                begin
                    sq_sum_reg     <= sq_with;
                    abs_sum_reg    <= abs_with;
                    block_peak_reg <= peak_with;
                    tally_reg      <= tally_with;
                end
            end
            if (cmd.load)
            begin
                if (snap_peak > peak_hold_reg)
                begin
                    peak_hold_reg <= snap_peak;
                end
                seen_reg <= seen_reg + 1'b1;
                if (snap_ovf)
                begin
                    dropped_reg <= dropped_reg + 1'b1;
                end
            end
            if (cmd.publish)
            begin
                floor_reg     <= floor_pub;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            res_peak_reg    <= (snap_peak > peak_hold_reg) ? snap_peak : peak_hold_reg;
            res_seen_reg    <= seen_reg + 1'b1;
            res_dropped_reg <= dropped_reg + COUNT_W'(snap_ovf);
            res_len_reg     <= snap_n;
            div_n_reg       <= snap_n;
            dq_sq_reg       <= snap_sq;
            dq_abs_reg      <= SQ_W'(snap_abs);
            rem_sq_reg      <= '0;
            rem_abs_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_sq_reg  <= ge_sq  ? CNT_W'(trial_sq - {1'b0, div_n_reg})  : CNT_W'(trial_sq);
            rem_abs_reg <= ge_abs ? CNT_W'(trial_abs - {1'b0, div_n_reg}) : CNT_W'(trial_abs);
            dq_sq_reg   <= {dq_sq_reg[SQ_W-2:0], ge_sq};
            dq_abs_reg  <= {dq_abs_reg[SQ_W-2:0], ge_abs};
        end

        if (cmd.sqrt_init)
        begin
            root_v_reg   <= QW'(dq_sq_reg);
            root_reg     <= '0;
            root_bit_reg <= QW'(1) << (QW - 1);
        end
        else if (cmd.sqrt_step)
        begin
            if (root_ge)
            begin
                root_v_reg <= QW'({1'b0, root_v_reg} - root_trial);
                root_reg   <= (root_reg >> 1) + {1'b0, root_bit_reg};
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            root_bit_reg <= root_bit_reg >> 2;
        end

        if (cmd.publish)
        begin
            rms_out_reg     <= LEVEL_W'(root_reg);
            mean_out_reg    <= LEVEL_W'(dq_abs_reg);
            peak_out_reg    <= LEVEL_W'(res_peak_reg);
            floor_out_reg   <= LEVEL_W'(floor_pub);
            seen_out_reg    <= res_seen_reg;
            dropped_out_reg <= res_dropped_reg;
            len_out_reg     <= LEN_W'(res_len_reg);
        end
    end

    assign out_valid      = out_valid_reg;
    assign rms_level      = rms_out_reg;
    assign mean_abs       = mean_out_reg;
    assign peak_level     = peak_out_reg;
    assign floor_level    = floor_out_reg;
    assign blocks_seen    = seen_out_reg;
    assign blocks_dropped = dropped_out_reg;
    assign block_length   = len_out_reg;

endmodule

// ----- rtl/core/audio_block_level_meter_top.sv -----
// Audio block level meter.
// Input channel (in_valid/in_ready): one signed sample per transfer, with last
// marking the final sample of a block and overflow taken with that sample.
// A sample that arrives when BLOCK_MAX samples are already held closes the held
// block (overflow treated as clear) and starts the next block.
// Output channel (out_valid/out_ready): one result per closed block with RMS,
// mean magnitude, peak hold, noise floor, block counters and block length.
// Throughput: one sample per cycle while the sequencer is idle. A closing transfer
// starts the divider and root unit; in_ready stays low while the bit-serial
// restoring divider and the one digit per cycle square root run and until the
// result is published. The result appears on out_valid in the same cycle that
// in_ready returns high.
// A stalled receiver: the result sits in the output register while the next
// block is accumulated. The next closing transfer is still taken, but its result
// then holds in the divider and root unit and in_ready stays low until the
// output register drains.
// Reset clears the accumulators, counters and peak hold and sets the noise
// floor to 1.0 (32768); no result is pending after reset.
module audio_block_level_meter_top
    import alm_pkg::*;
#(
    parameter int BLOCK_MAX   = BLOCK_MAX_DEFAULT,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          last,
    input  logic                          overflow,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [LEVEL_W-1:0]            rms_level,
    output logic [LEVEL_W-1:0]            mean_abs,
    output logic [LEVEL_W-1:0]            peak_level,
    output logic [LEVEL_W-1:0]            floor_level,
    output logic [COUNT_W-1:0]            blocks_seen,
    output logic [COUNT_W-1:0]            blocks_dropped,
    output logic [LEN_W-1:0]              block_length
);

    alm_cmd_t  cmd;
    alm_stat_t stat;

    // sequencer: accept, divide, root, publish
    alm_ctrl #(
        .BLOCK_MAX   (BLOCK_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // accumulators, divider, root unit and output register
    alm_dp #(
        .BLOCK_MAX   (BLOCK_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .sample         (sample),
        .last           (last),
        .overflow       (overflow),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rms_level      (rms_level),
        .mean_abs       (mean_abs),
        .peak_level     (peak_level),
        .floor_level    (floor_level),
        .blocks_seen    (blocks_seen),
        .blocks_dropped (blocks_dropped),
        .block_length   (block_length)
    );

endmodule
